// File: rtl/core/crb_pkg.sv
// package for the cigar reference-to-read-base block
// types, codes and constants shared by the crb front, back and top modules; no dependencies
`timescale 1ns / 1ps

package crb_pkg;

    localparam int MAX_READ_DEFAULT = 1024;
    localparam int ADDR_MAX_W       = 16;   // store address width at the largest read size
    localparam int REQ_DEPTH        = 4;
    localparam int OUT_DEPTH        = 4;
    localparam int OFFSET_W         = 31;

    // input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CIGAR = 1'b1;

    // configuration register indexes
    localparam logic REG_TARGET_OFFSET = 1'b0;
    localparam logic REG_MARKER_MODE   = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_FOUND      = 2'd0;
    localparam logic [1:0] STATUS_DELETION   = 2'd1;
    localparam logic [1:0] STATUS_UNRESOLVED = 2'd2;
    localparam logic [1:0] STATUS_RANGE      = 2'd3;

    // ascii characters
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_M     = 8'd77;
    localparam logic [7:0] CH_I     = 8'd73;
    localparam logic [7:0] CH_D     = 8'd68;
    localparam logic [7:0] CH_S     = 8'd83;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_X     = 8'd88;
    localparam logic [7:0] CH_DASH  = 8'd45;

    typedef enum logic [2:0] {
        REQ_LOAD,
        REQ_LOOKUP,
        REQ_DELETION,
        REQ_UNRESOLVED,
        REQ_RANGE
    } crb_req_kind_t;

    typedef struct packed {
        crb_req_kind_t           kind;
        logic [ADDR_MAX_W-1:0]   addr;
        logic [7:0]              data;
        logic                    marker;
    } crb_req_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last;
    } crb_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] base;
        logic [9:0] read_index;
        logic       mark;
    } crb_out_t;

endpackage

// File: rtl/core/crb_fifo.sv
// small register queue used between the crb stages
// generic width and depth; no package dependencies
`timescale 1ns / 1ps

module crb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

endmodule

// File: rtl/core/crb_front.sv
// front stage: accepts items, parses cigar characters and tracks the alignment walk
// emits at most one store or result request per item into the request queue; uses crb_pkg
`timescale 1ns / 1ps

module crb_front #(
    parameter int MAX_READ = crb_pkg::MAX_READ_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  crb_pkg::crb_in_t                item,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [crb_pkg::OFFSET_W-1:0]    cfg_data,
    output logic                            req_push,
    output crb_pkg::crb_req_t               req,
    input  logic                            req_full
);

    import crb_pkg::*;

    localparam int CW = $clog2(MAX_READ + 1);

    logic [OFFSET_W-1:0] target_offset_reg, target_offset_next;
    logic                marker_mode_reg, marker_mode_next;
    logic [CW-1:0]       load_count_reg, load_count_next;
    logic [15:0]         read_position_reg, read_position_next;
    logic signed [31:0]  countdown_reg, countdown_next;
    logic [15:0]         length_reg, length_next;
    logic                resolved_reg, resolved_next;

    logic                accept;
    logic                is_digit;
    logic                steps_both;
    logic                steps_read;
    logic                is_del;
    logic [19:0]         acc_ext;
    logic [19:0]         acc_sum;
    logic signed [31:0]  cd_new;
    logic [16:0]         rp_sum;
    logic [15:0]         rp_new;
    logic                resolve;
    logic signed [17:0]  idx;
    logic                in_range;

    assign full   = req_full;
    assign accept = push && !req_full;

    assign is_digit   = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);
    assign steps_both = (item.data_byte == CH_M) || (item.data_byte == CH_EQ)
                     || (item.data_byte == CH_X);
    assign steps_read = (item.data_byte == CH_I) || (item.data_byte == CH_S);
    assign is_del     = (item.data_byte == CH_D);

    // length * 10 + digit, saturated at 16 bits
    assign acc_ext = {4'b0, length_reg};
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {16'b0, item.data_byte[3:0]};

    assign cd_new = (steps_both || is_del)
                  ? countdown_reg - $signed({16'b0, length_reg}) : countdown_reg;
    assign rp_sum = {1'b0, read_position_reg} + ((steps_both || steps_read)
                  ? {1'b0, length_reg} : 17'd0);
    assign rp_new = rp_sum[16] ? 16'hffff : rp_sum[15:0];

    assign resolve = !is_digit && (cd_new[31] || (cd_new == 32'sd0));

    // overshoot pulls the index back; negative countdown is never below -65535
    assign idx = $signed({2'b0, rp_new}) - 18'sd1
               + (cd_new[31] ? $signed(cd_new[17:0]) : 18'sd0);
    assign in_range = !idx[17] && ({1'b0, idx[16:0]} < 18'(load_count_reg));

    always_comb
    begin
        target_offset_next = target_offset_reg;
        marker_mode_next   = marker_mode_reg;
        load_count_next    = load_count_reg;
        read_position_next = read_position_reg;
        countdown_next     = countdown_reg;
        length_next        = length_reg;
        resolved_next      = resolved_reg;
        req_push           = 1'b0;
        req                = '0;
        req.marker         = marker_mode_reg;

        if (accept)
        begin
            if (item.command == CMD_LOAD)
            begin
                if (load_count_reg < CW'(MAX_READ))
                begin
                    req_push        = 1'b1;
                    req.kind        = REQ_LOAD;
                    req.addr        = ADDR_MAX_W'(load_count_reg);
                    req.data        = item.data_byte;
                    load_count_next = load_count_reg + 1'b1;
                end
            end
            else
            begin
                if (!resolved_reg)
                begin
                    if (is_digit)
                    begin
                        length_next = (acc_sum > 20'hffff) ? 16'hffff : acc_sum[15:0];
                    end
                    else
                    begin
                        length_next        = '0;
                        countdown_next     = cd_new;
                        read_position_next = rp_new;
                    end
                    if (resolve)
                    begin
                        resolved_next = 1'b1;
                        req_push      = 1'b1;
                        if (is_del)
                        begin
                            req.kind = REQ_DELETION;
                        end
                        else if (in_range)
                        begin
                            req.kind = REQ_LOOKUP;
                            req.addr = idx[ADDR_MAX_W-1:0];
                        end
                        else
                        begin
                            req.kind = REQ_RANGE;
                        end
                    end
                    else if (item.last)
                    begin
                        req_push = 1'b1;
                        req.kind = REQ_UNRESOLVED;
                    end
                end
                if (item.last)
                begin
                    load_count_next    = '0;
                    read_position_next = '0;
                    countdown_next     = $signed({1'b0, target_offset_reg});
                    length_next        = '0;
                    resolved_next      = 1'b0;
                end
            end
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_OFFSET:
                begin
                    target_offset_next = cfg_data;
                    countdown_next     = $signed({1'b0, cfg_data});
                end
                REG_MARKER_MODE:
                begin
                    marker_mode_next = cfg_data[0];
                end
                default:
                begin
                    marker_mode_next = marker_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_offset_reg <= OFFSET_W'(1);
            marker_mode_reg   <= 1'b0;
            load_count_reg    <= '0;
            read_position_reg <= '0;
            countdown_reg     <= 32'sd1;
            length_reg        <= '0;
            resolved_reg      <= 1'b0;
        end
        else
        begin
            target_offset_reg <= target_offset_next;
            marker_mode_reg   <= marker_mode_next;
            load_count_reg    <= load_count_next;
            read_position_reg <= read_position_next;
            countdown_reg     <= countdown_next;
            length_reg        <= length_next;
            resolved_reg      <= resolved_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.command == CMD_CIGAR) && item.last && !cfg_write
        |=> !resolved_reg && (load_count_reg == '0) && (length_reg == '0))
        else $error("cigar state not cleared after last item");

    a_one_resolution: assert property (@(posedge clk) disable iff (!rst_n)
        req_push && (req.kind != REQ_LOAD) |-> !resolved_reg)
        else $error("result request issued after resolution");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= CW'(MAX_READ))
        else $error("load count past read store size");

    // an offset write may reload the countdown later, so only the moment of resolution
    a_resolved_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resolved_reg) |-> (countdown_reg[31] || (countdown_reg == 32'sd0)))
        else $error("resolved with positive countdown");

endmodule

// File: rtl/core/crb_back.sv
// back stage: read store writes and lookups, result formatting and the result queue
// takes requests from the front request queue; uses crb_pkg and crb_fifo
`timescale 1ns / 1ps

module crb_back #(
    parameter int MAX_READ = crb_pkg::MAX_READ_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  crb_pkg::crb_req_t  req,
    input  logic               req_empty,
    output logic               req_pop,
    output logic               empty,
    input  logic               pop,
    output crb_pkg::crb_out_t  result
);

    import crb_pkg::*;

    localparam int AW  = $clog2(MAX_READ);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic [7:0]          store_mem [MAX_READ];
    logic [7:0]          rdata_reg;
    logic                s1_valid_reg, s1_valid_next;
    crb_req_kind_t       s1_kind_reg;
    logic [9:0]          s1_index_reg;
    logic                s1_marker_reg;

    crb_out_t            fmt;
    logic [OCW-1:0]      out_count;
    logic                out_full;
    logic [OUT_DEPTH*0+$bits(crb_out_t)-1:0] out_dout;

    // room for the result in flight plus anything the new request may produce
    assign req_pop = !req_empty
                  && (({1'b0, out_count} + (OCW+1)'(s1_valid_reg)) < (OCW+1)'(OUT_DEPTH));
    assign s1_valid_next = req_pop && (req.kind != REQ_LOAD);

    always_ff @(posedge clk)
    begin
        if (req_pop && (req.kind == REQ_LOAD))
        begin
            store_mem[req.addr[AW-1:0]] <= req.data;
        end
        if (req_pop && (req.kind == REQ_LOOKUP))
        begin
            rdata_reg <= store_mem[req.addr[AW-1:0]];
        end
        if (req_pop)
        begin
            s1_kind_reg   <= req.kind;
            s1_index_reg  <= req.addr[9:0];
            s1_marker_reg <= req.marker;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_comb
    begin
        fmt = '0;
        case (s1_kind_reg)
            REQ_LOOKUP:
            begin
                fmt.status     = STATUS_FOUND;
                fmt.base       = s1_marker_reg ? 8'd0 : rdata_reg;
                fmt.read_index = s1_marker_reg ? 10'd0 : s1_index_reg;
                fmt.mark       = (rdata_reg != CH_EQ);
            end
            REQ_DELETION:
            begin
                fmt.status = STATUS_DELETION;
                fmt.base   = s1_marker_reg ? 8'd0 : CH_DASH;
                fmt.mark   = 1'b1;
            end
            REQ_UNRESOLVED:
            begin
                fmt.status = STATUS_UNRESOLVED;
            end
            REQ_RANGE:
            begin
                fmt.status = STATUS_RANGE;
            end
            default:
            begin
                fmt = '0;
            end
        endcase
    end

    crb_fifo #(
        .WIDTH ($bits(crb_out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s1_valid_reg),
        .din   (fmt),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty),
        .count (out_count)
    );

    assign result = crb_out_t'(out_dout);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !out_full)
        else $error("result dropped at full result queue");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop && (req.kind == REQ_LOAD) |=> !s1_valid_reg)
        else $error("store write produced a result");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, out_count} + (OCW+1)'(s1_valid_reg)) <= (OCW+1)'(OUT_DEPTH))
        else $error("results in flight exceed queue space");

endmodule

// File: rtl/core/cigar_ref_to_read_base.sv
// Finds the read base aligned to one reference position. Bases are pushed with
// command 0 into a read store, then the CIGAR string one character per item with
// command 1; the CIGAR item marked last ends the read and clears the walk. One
// item is taken per clock while full is low. The front parses and pushes a
// request into a four-entry queue; the back writes or reads the store (registered
// read) and fills a four-entry result queue. full rises when the request queue
// is full, which happens only while the result queue holds back requests. The
// user must ensure the target offset and marker mode are written only while
// the block is idle; the block itself does not enforce it.
// top level; uses crb_pkg, crb_front, crb_fifo and crb_back
`timescale 1ns / 1ps

module cigar_ref_to_read_base #(
    parameter int MAX_READ = crb_pkg::MAX_READ_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  crb_pkg::crb_in_t              item,
    output logic                          empty,
    input  logic                          pop,
    output crb_pkg::crb_out_t             result,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [crb_pkg::OFFSET_W-1:0]  cfg_data
);

    import crb_pkg::*;

    localparam int RCW = $clog2(REQ_DEPTH + 1);

    logic                      req_push;
    crb_req_t                  req_in;
    logic                      req_full;
    logic                      req_pop;
    logic                      req_empty;
    logic [$bits(crb_req_t)-1:0] req_dout;
    logic [RCW-1:0]            req_count;
    crb_req_t                  req_out;

    crb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_push  (req_push),
        .req       (req_in),
        .req_full  (req_full)
    );

    crb_fifo #(
        .WIDTH ($bits(crb_req_t)),
        .DEPTH (REQ_DEPTH)
    ) u_req_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (req_push),
        .din   (req_in),
        .full  (req_full),
        .pop   (req_pop),
        .dout  (req_dout),
        .empty (req_empty),
        .count (req_count)
    );

    assign req_out = crb_req_t'(req_dout);

    crb_back #(
        .MAX_READ (MAX_READ)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_out),
        .req_empty (req_empty),
        .req_pop   (req_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        req_empty |-> (req_count == '0))
        else $error("request queue empty flag disagrees with count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (req_count == RCW'(REQ_DEPTH)))
        else $error("full raised with room in request queue");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |=> (req_count <= RCW'(REQ_DEPTH)))
        else $error("request queue count out of range");

endmodule

// File: tb/tb.sv
// testbench for cigar_ref_to_read_base: a directed table, a full-store read, then random reads
// every result is checked field by field against a cycle-free predictor of the base lookup
// or a pinned table value; depends on crb_pkg and the cigar_ref_to_read_base rtl
`timescale 1ns / 1ps

module tb;
    import crb_pkg::*;

    localparam int STORE_DEPTH   = MAX_READ_DEFAULT;
    localparam int TOTAL_ITEMS   = 1650;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT     = 65535;

    localparam logic [7:0] CH_N = 8'd78;
    localparam logic [7:0] CH_H = 8'd72;
    localparam logic [7:0] CH_P = 8'd80;
    localparam logic [7:0] CIGAR_OPS [9] =
        '{CH_M, CH_EQ, CH_X, CH_I, CH_S, CH_D, CH_N, CH_H, CH_P};
    localparam int LONG_RUNS [4] = '{65535, 70000, 123456, 9999999};

    typedef struct packed {
        crb_in_t  it;
        logic     pin;
        crb_out_t want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    crb_in_t             item;
    logic                empty;
    logic                pop;
    crb_out_t            result;
    logic                cfg_write;
    logic                cfg_index;
    logic [OFFSET_W-1:0] cfg_data;

    // typed-in expectation that travels with the item being driven
    logic     drv_pin;
    crb_out_t drv_want;
    bit       tx_steady;
    bit       rx_steady;

    // predictor state
    logic [7:0]          read_bases [STORE_DEPTH];
    int unsigned         bases_loaded = 0;
    int unsigned         read_pos = 0;
    longint              ref_left = 1;
    int unsigned         run_len = 0;
    bit                  located = 1'b0;
    logic [OFFSET_W-1:0] offset_reg = 1;
    logic                marker_reg = 1'b0;

    crb_out_t pending_bases [$];
    int       mismatches = 0;
    int       items_sent = 0;

    cigar_ref_to_read_base i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void restart_read();
        bases_loaded = 0;
        read_pos = 0;
        ref_left = longint'(offset_reg);
        run_len = 0;
        located = 1'b0;
    endfunction

    function automatic void advance_read(int unsigned len);
        read_pos = (read_pos + len > RUN_LIMIT) ? RUN_LIMIT : read_pos + len;
    endfunction

    // returns 1 when the item yields a result, which is left in r
    function automatic bit locate_base(crb_in_t it, output crb_out_t r);
        int unsigned len;
        int unsigned v;
        bit          del;
        bit          got;
        longint      idx;
        logic [7:0]  b;
        got = 1'b0;
        r = '0;
        if (it.command == CMD_LOAD) begin
            if (bases_loaded < STORE_DEPTH) begin
                read_bases[bases_loaded] = it.data_byte;
                bases_loaded++;
            end
            return 1'b0;
        end
        if (!located) begin
            if (it.data_byte >= CH_ZERO && it.data_byte <= CH_NINE) begin
                v = run_len * 10 + (it.data_byte - CH_ZERO);
                run_len = (v > RUN_LIMIT) ? RUN_LIMIT : v;
            end else begin
                len = run_len;
                run_len = 0;
                del = 1'b0;
                case (it.data_byte)
                    CH_M, CH_EQ, CH_X: begin
                        ref_left -= longint'(len);
                        advance_read(len);
                    end
                    CH_I, CH_S: advance_read(len);
                    CH_D: begin
                        ref_left -= longint'(len);
                        del = 1'b1;
                    end
                    default: ;
                endcase
                if (ref_left <= 0) begin
                    located = 1'b1;
                    got = 1'b1;
                    if (del) begin
                        r = '{STATUS_DELETION, marker_reg ? 8'd0 : CH_DASH, 10'd0, 1'b1};
                    end else begin
                        idx = longint'(read_pos) - 1;
                        if (ref_left < 0)
                            idx += ref_left;
                        if (idx < 0 || idx >= longint'(bases_loaded)) begin
                            r = '{STATUS_RANGE, 8'd0, 10'd0, 1'b0};
                        end else begin
                            b = read_bases[idx];
                            r.status = STATUS_FOUND;
                            r.mark = (b != CH_EQ);
                            if (!marker_reg) begin
                                r.base = b;
                                r.read_index = idx[9:0];
                            end
                        end
                    end
                end
            end
            if (it.last && !located) begin
                r = '{STATUS_UNRESOLVED, 8'd0, 10'd0, 1'b0};
                got = 1'b1;
            end
        end
        if (it.last)
            restart_read();
        return got;
    endfunction

    function automatic void check_field(string what, logic [9:0] want, logic [9:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        crb_out_t want;
        crb_out_t got;
        if (rst_n) begin
            if (pop && !empty) begin
                if (pending_bases.size() == 0) begin
                    $display("%0t: unexpected result, status %0d base %0d index %0d mark %0d",
                             $time, result.status, result.base, result.read_index,
                             result.mark);
                    mismatches++;
                end else begin
                    want = pending_bases.pop_front();
                    check_field("status", 10'(want.status), 10'(result.status));
                    check_field("base", 10'(want.base), 10'(result.base));
                    check_field("read_index", want.read_index, result.read_index);
                    check_field("mark", 10'(want.mark), 10'(result.mark));
                end
            end
            if (cfg_write) begin
                if (cfg_index == REG_TARGET_OFFSET) begin
                    offset_reg = cfg_data;
                    ref_left = longint'(cfg_data);
                end else begin
                    marker_reg = cfg_data[0];
                end
            end
            if (push && !full) begin
                if (locate_base(item, got) || drv_pin)
                    pending_bases.insert(pending_bases.size(), drv_pin ? drv_want : got);
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_base();
        string nts;
        int    r;
        nts = "ACGTN";
        r = $urandom_range(0, 99);
        if (r < 30)
            return CH_EQ;
        if (r < 80)
            return nts[$urandom_range(0, 4)];
        return 8'($urandom);
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 30)
            return OFFSET_W'(1);
        if (r < 80)
            return OFFSET_W'($urandom_range(2, 30));
        if (r < 90)
            return {OFFSET_W{1'b1}};
        return OFFSET_W'($urandom);
    endfunction

    function automatic dir_row_t row_of(logic cmd, logic [7:0] ch, logic lst);
        return '{'{cmd, ch, lst}, 1'b0, '0};
    endfunction

    function automatic dir_row_t row_pinned(logic cmd, logic [7:0] ch, logic lst,
                                            logic [1:0] st, logic [7:0] b,
                                            logic [9:0] idx, logic mk);
        return '{'{cmd, ch, lst}, 1'b1, '{st, b, idx, mk}};
    endfunction

    task automatic send(crb_in_t it, logic pin = 1'b0, crb_out_t want = '0);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        drv_pin <= pin;
        drv_want <= want;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_load(logic [7:0] b);
        send('{CMD_LOAD, b, 1'b0});
    endtask

    task automatic send_cigar(logic [7:0] ch, logic lst);
        send('{CMD_CIGAR, ch, lst});
    endtask

    task automatic send_len(int n);
        string digits;
        digits = $sformatf("%0d", n);
        for (int k = 0; k < digits.len(); k++)
            send_cigar(digits[k], 1'b0);
    endtask

    // block is idle once every result is in and the store pipeline has drained
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_bases.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [OFFSET_W-1:0] offset, logic marker, bit both);
        logic [OFFSET_W-1:0] noise;
        noise = OFFSET_W'($urandom);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_TARGET_OFFSET;
        cfg_data <= offset;
        if (both) begin
            @(negedge clk);
            cfg_index <= REG_MARKER_MODE;
            cfg_data <= {noise[OFFSET_W-1:1], marker};
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_read();
        int         n_bases;
        int         n_ops;
        int         len;
        int         r;
        logic [7:0] op;
        bit         closed;
        bit         mid_load;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            // raw noise: any command, any byte, any last
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 2) == 0)
                    send('{CMD_LOAD, 8'($urandom), 1'($urandom)});
                else
                    send_cigar(8'($urandom), $urandom_range(0, 4) == 0);
            end
            return;
        end
        n_bases = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 60);
        repeat (n_bases) send_load(pick_base());
        n_ops = $urandom_range(1, 6);
        closed = $urandom_range(0, 19) != 0;
        mid_load = $urandom_range(0, 9) == 0;
        for (int k = 0; k < n_ops; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = -1;
            else if (r < 92)
                len = $urandom_range(0, n_bases / 2 + 3);
            else
                len = LONG_RUNS[$urandom_range(0, 3)];
            if ($urandom_range(0, 19) == 0)
                op = 8'($urandom);
            else
                op = CIGAR_OPS[$urandom_range(0, 8)];
            if (len >= 0)
                send_len(len);
            if (mid_load && k == 0)
                send_load(pick_base());
            send_cigar(op, closed && k == n_ops - 1);
        end
    endtask

    initial begin
        int unsigned rx_gap;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            repeat ($urandom_range(1, 40)) begin
                @(negedge clk);
                pop <= 1'b1;
            end
            rx_gap = rx_steady ? 0 : idle_len();
            if (rx_gap > 0) begin
                @(negedge clk);
                pop <= 1'b0;
                repeat (rx_gap - 1) @(negedge clk);
            end
        end
    end

    initial begin
        dir_row_t directed [25];
        int       phase;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = REG_TARGET_OFFSET;
        cfg_data = '0;
        drv_pin = 1'b0;
        drv_want = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        directed = '{
            row_of(CMD_LOAD, "A", 1'b0),
            row_of(CMD_LOAD, CH_EQ, 1'b0),
            row_of(CMD_LOAD, 8'hFF, 1'b0),
            row_of(CMD_LOAD, 8'h00, 1'b0),
            row_of(CMD_CIGAR, "1", 1'b0),
            row_of(CMD_CIGAR, CH_I, 1'b0),
            row_of(CMD_CIGAR, CH_P, 1'b0),
            row_of(CMD_CIGAR, 8'h00, 1'b0),
            row_of(CMD_CIGAR, 8'hFF, 1'b0),
            row_of(CMD_CIGAR, "1", 1'b0),
            row_pinned(CMD_CIGAR, CH_EQ, 1'b0, STATUS_FOUND, CH_EQ, 10'd1, 1'b0),
            row_of(CMD_CIGAR, CH_X, 1'b1),
            row_of(CMD_CIGAR, "1", 1'b0),
            row_pinned(CMD_CIGAR, CH_D, 1'b1, STATUS_DELETION, CH_DASH, 10'd0, 1'b1),
            row_pinned(CMD_CIGAR, CH_H, 1'b1, STATUS_UNRESOLVED, 8'd0, 10'd0, 1'b0),
            row_of(CMD_CIGAR, CH_N, 1'b0),
            row_of(CMD_CIGAR, "2", 1'b0),
            row_pinned(CMD_CIGAR, CH_M, 1'b0, STATUS_RANGE, 8'd0, 10'd0, 1'b0),
            row_of(CMD_CIGAR, CH_S, 1'b1),
            row_of(CMD_LOAD, "G", 1'b0),
            row_of(CMD_LOAD, "T", 1'b1),
            row_of(CMD_CIGAR, "0", 1'b0),
            row_of(CMD_CIGAR, CH_S, 1'b0),
            row_of(CMD_CIGAR, "9", 1'b0),
            row_pinned(CMD_CIGAR, CH_X, 1'b1, STATUS_FOUND, "G", 10'd0, 1'b1)
        };
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
            send(directed[k].it, directed[k].pin, directed[k].want);
        wait_idle();

        // overfill the store and resolve on its top entry
        configure(OFFSET_W'(STORE_DEPTH), 1'b0, 1'b1);
        repeat (STORE_DEPTH + 2) send_load(pick_base());
        send_len(STORE_DEPTH);
        send_cigar(CH_M, 1'b1);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            wait_idle();
            configure(pick_offset(), 1'($urandom_range(0, 1)),
                      phase == 0 || $urandom_range(0, 2) != 0);
            tx_steady = $urandom_range(0, 3) == 0;
            rx_steady = $urandom_range(0, 3) == 0;
            repeat ($urandom_range(3, 10)) random_read();
            phase++;
        end
        wait_idle();

        if (mismatches == 0 && pending_bases.size() == 0)
            $display("cigar_ref_to_read_base regression: pass");
        else
            $display("cigar_ref_to_read_base regression: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("cigar_ref_to_read_base regression: fail");
        $finish;
    end

endmodule
